// File: hw/rtl/lr_pkg.sv
// Shared types, widths and codes for the line rasterizer.
package lr_pkg;

	localparam int COORD_WIDTH = 12;
	localparam int DELTA_WIDTH = COORD_WIDTH + 2;
	localparam int ERR_WIDTH   = COORD_WIDTH + 4;
	localparam int COLOR_WIDTH = 24;

	// Unit step for the walker's coordinates, which carry one extra bit.
	localparam logic signed [COORD_WIDTH:0] COORD_ONE = (COORD_WIDTH+1)'(1);

	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_STEP = 1'b1;

	localparam logic [1:0] OCT_SHALLOW_RISE = 2'd0;
	localparam logic [1:0] OCT_STEEP_RISE   = 2'd1;
	localparam logic [1:0] OCT_SHALLOW_FALL = 2'd2;
	localparam logic [1:0] OCT_STEEP_FALL   = 2'd3;

	typedef struct packed {
		logic                          mode;
		logic signed [COORD_WIDTH-1:0] start_x;
		logic signed [COORD_WIDTH-1:0] start_y;
		logic signed [COORD_WIDTH-1:0] finish_x;
		logic signed [COORD_WIDTH-1:0] finish_y;
	} cmd_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] pixel_x;
		logic signed [COORD_WIDTH-1:0] pixel_y;
		logic [COLOR_WIDTH-1:0]        pixel_rgb;
		logic                          final_pixel;
	} pix_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] walk_x;
		logic signed [COORD_WIDTH-1:0] walk_y;
		logic signed [COORD_WIDTH-1:0] stop_x;
		logic signed [COORD_WIDTH-1:0] stop_y;
		logic [DELTA_WIDTH-1:0]        delta_x2;
		logic [DELTA_WIDTH-1:0]        delta_y2;
		logic signed [ERR_WIDTH-1:0]   error_term;
		logic [1:0]                    octant;
	} setup_t;

endpackage

// File: hw/rtl/lr_setup.sv
// Line setup: endpoint ordering, doubled deltas, octant choice and initial error.
module lr_setup import lr_pkg::*; (
	input  cmd_t   cmd,
	output setup_t setup
);

	logic                          swap;
	logic signed [COORD_WIDTH-1:0] ax, ay, bx, by;
	logic signed [COORD_WIDTH:0]   run, rise;
	logic signed [DELTA_WIDTH-1:0] run_w, rise_w, dx2, dy2, neg_dy2;
	logic signed [ERR_WIDTH-1:0]   run_e, rise_e, dx2_e, dy2_e;
	logic                          rising, shallow;

	assign swap = cmd.start_x > cmd.finish_x;
	assign ax   = swap ? cmd.finish_x : cmd.start_x;
	assign ay   = swap ? cmd.finish_y : cmd.start_y;
	assign bx   = swap ? cmd.start_x  : cmd.finish_x;
	assign by   = swap ? cmd.start_y  : cmd.finish_y;

	assign run  = (COORD_WIDTH+1)'(bx) - (COORD_WIDTH+1)'(ax);
	assign rise = (COORD_WIDTH+1)'(by) - (COORD_WIDTH+1)'(ay);

	assign run_w   = DELTA_WIDTH'(run);
	assign rise_w  = DELTA_WIDTH'(rise);
	assign dx2     = {run, 1'b0};
	assign dy2     = {rise, 1'b0};
	assign neg_dy2 = -dy2;

	assign run_e  = ERR_WIDTH'(run_w);
	assign rise_e = ERR_WIDTH'(rise_w);
	assign dx2_e  = ERR_WIDTH'(dx2);
	assign dy2_e  = ERR_WIDTH'(dy2);

	// A flat line counts as falling.
	assign rising  = dy2 > 0;
	assign shallow = rising ? (dx2 > dy2) : (dx2 > neg_dy2);

	always_comb begin
		setup.walk_x   = ax;
		setup.walk_y   = ay;
		setup.stop_x   = bx;
		setup.stop_y   = by;
		setup.delta_x2 = dx2;
		setup.delta_y2 = rising ? dy2 : neg_dy2;
		case ({rising, shallow})
			2'b11: begin
				setup.octant     = OCT_SHALLOW_RISE;
				setup.error_term = dy2_e - run_e;
			end
			2'b10: begin
				setup.octant     = OCT_STEEP_RISE;
				setup.error_term = rise_e - dx2_e;
			end
			2'b01: begin
				setup.octant     = OCT_SHALLOW_FALL;
				setup.error_term = run_e + dy2_e;
			end
			default: begin
				setup.octant     = OCT_STEEP_FALL;
				setup.error_term = dx2_e + rise_e;
			end
		endcase
	end

endmodule

// File: hw/rtl/lr_walker.sv
// Walker state and the per-pixel Bresenham step.
module lr_walker import lr_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  logic                   step,
	input  setup_t                 setup,
	input  logic [COLOR_WIDTH-1:0] color,
	output logic                   emit,
	output pix_t                   pixel
);

	logic signed [COORD_WIDTH-1:0] walk_x_q, walk_y_q, stop_x_q, stop_y_q;
	logic [DELTA_WIDTH-1:0]        delta_x2_q, delta_y2_q;
	logic signed [ERR_WIDTH-1:0]   error_q;
	logic [1:0]                    octant_q;
	logic                          active_q;

	logic signed [COORD_WIDTH:0]   x_e, y_e, stop_x_e, stop_y_e, nx, ny;
	logic signed [ERR_WIDTH-1:0]   dx_e, m_e, nd;
	logic                          fin;

	assign x_e      = (COORD_WIDTH+1)'(walk_x_q);
	assign y_e      = (COORD_WIDTH+1)'(walk_y_q);
	assign stop_x_e = (COORD_WIDTH+1)'(stop_x_q);
	assign stop_y_e = (COORD_WIDTH+1)'(stop_y_q);
	assign dx_e     = ERR_WIDTH'(delta_x2_q);
	assign m_e      = ERR_WIDTH'(delta_y2_q);

	// The coordinate may run one past the end point, so the compare is one bit wider.
	always_comb begin
		nx = x_e;
		ny = y_e;
		nd = error_q;
		case (octant_q)
			OCT_SHALLOW_RISE: begin
				if (error_q < 0) begin
					nd = error_q + m_e;
				end else begin
					ny = y_e + COORD_ONE;
					nd = error_q + m_e - dx_e;
				end
				nx  = x_e + COORD_ONE;
				fin = !(nx <= stop_x_e);
			end
			OCT_STEEP_RISE: begin
				if (error_q > 0) begin
					nd = error_q - dx_e;
				end else begin
					nx = x_e + COORD_ONE;
					nd = error_q + m_e - dx_e;
				end
				ny  = y_e + COORD_ONE;
				fin = !(ny <= stop_y_e);
			end
			OCT_SHALLOW_FALL: begin
				if (error_q > 0) begin
					nd = error_q - m_e;
				end else begin
					ny = y_e - COORD_ONE;
					nd = error_q + dx_e - m_e;
				end
				nx  = x_e + COORD_ONE;
				fin = !(nx <= stop_x_e);
			end
			default: begin
				if (error_q < 0) begin
					nd = error_q + dx_e;
				end else begin
					nx = x_e + COORD_ONE;
					nd = error_q + dx_e - m_e;
				end
				ny  = y_e - COORD_ONE;
				fin = !(ny >= stop_y_e);
			end
		endcase
	end

	assign emit              = step && active_q;
	assign pixel.pixel_x     = walk_x_q;
	assign pixel.pixel_y     = walk_y_q;
	assign pixel.pixel_rgb   = color;
	assign pixel.final_pixel = fin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_x_q   <= '0;
			walk_y_q   <= '0;
			stop_x_q   <= '0;
			stop_y_q   <= '0;
			delta_x2_q <= '0;
			delta_y2_q <= '0;
			error_q    <= '0;
			octant_q   <= OCT_SHALLOW_RISE;
			active_q   <= 1'b0;
		end else if (load) begin
			walk_x_q   <= setup.walk_x;
			walk_y_q   <= setup.walk_y;
			stop_x_q   <= setup.stop_x;
			stop_y_q   <= setup.stop_y;
			delta_x2_q <= setup.delta_x2;
			delta_y2_q <= setup.delta_y2;
			error_q    <= setup.error_term;
			octant_q   <= setup.octant;
			active_q   <= 1'b1;
		end else if (emit) begin
			walk_x_q <= nx[COORD_WIDTH-1:0];
			walk_y_q <= ny[COORD_WIDTH-1:0];
			error_q  <= nd;
			if (fin) begin
				active_q <= 1'b0;
			end
		end
	end

endmodule

// File: hw/rtl/line_rasterizer_unit.sv
// Bresenham line rasterizer: a load command sets up a line, and each step command
// then returns one pixel, the last one flagged, until the line is done. Commands are
// taken one per clock while the pixel output is not stalled. A step's pixel passes
// through the command register, then the walker update that feeds the pixel
// register. Sustained rate is one pixel per clock while unstalled, set by the
// walker update of x, y and the error term. Steps sent while no line is active, and
// load commands, produce no pixel; a load abandons any line in progress. The color
// register is written over the config port, which is always ready.
module line_rasterizer_unit import lr_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [COLOR_WIDTH-1:0] cfg_data,
	input  logic                   cmd_valid,
	output logic                   cmd_stall,
	input  cmd_t                   cmd,
	output logic                   pix_valid,
	input  logic                   pix_stall,
	output pix_t                   pix
);

	logic [COLOR_WIDTH-1:0] color_q;
	cmd_t                   cmd_s1;
	logic                   valid_s1;
	pix_t                   pix_q;
	logic                   pix_valid_q;

	logic   out_free, advance, load, step, emit;
	setup_t setup;
	pix_t   pixel;

	assign cfg_ready = 1'b1;

	assign out_free  = !pix_valid_q || !pix_stall;
	assign advance   = valid_s1 && out_free;
	assign cmd_stall = valid_s1 && !out_free;
	assign load      = advance && (cmd_s1.mode == MODE_LOAD);
	assign step      = advance && (cmd_s1.mode == MODE_STEP);

	lr_setup u_setup (
		.cmd   (cmd_s1),
		.setup (setup)
	);

	lr_walker u_walker (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (load),
		.step   (step),
		.setup  (setup),
		.color  (color_q),
		.emit   (emit),
		.pixel  (pixel)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			color_q <= cfg_data;
		end
	end

	// The command register refills whenever it is empty or its item moves on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!cmd_stall) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall) begin
			cmd_s1 <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_valid_q <= 1'b0;
		end else if (out_free) begin
			pix_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && emit) begin
			pix_q <= pixel;
		end
	end

	assign pix_valid = pix_valid_q;
	assign pix       = pix_q;

endmodule

// File: test/testbench.sv
// Self-checking testbench for the line rasterizer: random and directed lines, checked per pixel.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import lr_pkg::*;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [COLOR_WIDTH-1:0] cfg_data = '0;
	logic                   cmd_valid = 1'b0;
	logic                   cmd_stall;
	cmd_t                   cmd = '0;
	logic                   pix_valid;
	logic                   pix_stall = 1'b0;
	pix_t                   pix;

	line_rasterizer_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pix       (pix)
	);

	// Commands waiting to be offered and pixels still owed by the block.
	cmd_t cmds_pending[$];
	pix_t pixels_due[$];
	int   items_queued = 0;
	int   items_sent = 0;
	int   items_made = 0;
	int   fail_count = 0;
	int   send_gap_pct = 0;
	int   recv_gap_pct = 0;
	int   hold_left = 0;
	bit   hold_armed = 1'b0;

	// Mirror of the line walker.
	logic [COLOR_WIDTH-1:0]        color_reg = '0;
	logic signed [COORD_WIDTH-1:0] pen_x = '0, pen_y = '0, end_x = '0, end_y = '0;
	logic [DELTA_WIDTH-1:0]        run2 = '0, rise2 = '0;
	logic signed [ERR_WIDTH-1:0]   slope_err = '0;
	logic [1:0]                    octant = OCT_SHALLOW_RISE;
	logic                          drawing = 1'b0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("testbench: done, errors");
		$finish;
	end

	task automatic trace_cmd(input cmd_t c);
		int  ax, ay, bx, by, tmp, dx, dy, m, x, y, d;
		logic fin;
		pix_t p;
		if (c.mode == MODE_LOAD) begin
			ax = int'(c.start_x);
			ay = int'(c.start_y);
			bx = int'(c.finish_x);
			by = int'(c.finish_y);
			if (ax > bx) begin
				tmp = ax; ax = bx; bx = tmp;
				tmp = ay; ay = by; by = tmp;
			end
			dx = (bx - ax) * 2;
			dy = (by - ay) * 2;
			pen_x = COORD_WIDTH'(ax);
			pen_y = COORD_WIDTH'(ay);
			end_x = COORD_WIDTH'(bx);
			end_y = COORD_WIDTH'(by);
			run2 = DELTA_WIDTH'(dx);
			// A flat line has no rise and is walked as a falling one.
			if (dy > 0) begin
				rise2 = DELTA_WIDTH'(dy);
				if (dx > dy) begin
					octant = OCT_SHALLOW_RISE;
					slope_err = ERR_WIDTH'(dy - dx / 2);
				end else begin
					octant = OCT_STEEP_RISE;
					slope_err = ERR_WIDTH'(dy / 2 - dx);
				end
			end else begin
				rise2 = DELTA_WIDTH'(-dy);
				if (dx > -dy) begin
					octant = OCT_SHALLOW_FALL;
					slope_err = ERR_WIDTH'(dx / 2 + dy);
				end else begin
					octant = OCT_STEEP_FALL;
					slope_err = ERR_WIDTH'(dx + dy / 2);
				end
			end
			drawing = 1'b1;
		end else if (drawing) begin
			dx = int'(run2);
			m = int'(rise2);
			x = int'(pen_x);
			y = int'(pen_y);
			d = int'(slope_err);
			p.pixel_x = pen_x;
			p.pixel_y = pen_y;
			p.pixel_rgb = color_reg;
			// The end test runs on full-width integers, so a step past the
			// coordinate range still ends the line.
			case (octant)
				OCT_SHALLOW_RISE: begin
					if (d < 0) d += m;
					else begin
						y++;
						d += m - dx;
					end
					x++;
					fin = x > int'(end_x);
				end
				OCT_STEEP_RISE: begin
					if (d > 0) d -= dx;
					else begin
						x++;
						d += m - dx;
					end
					y++;
					fin = y > int'(end_y);
				end
				OCT_SHALLOW_FALL: begin
					if (d > 0) d -= m;
					else begin
						y--;
						d += dx - m;
					end
					x++;
					fin = x > int'(end_x);
				end
				default: begin
					if (d < 0) d += dx;
					else begin
						x++;
						d += dx - m;
					end
					y--;
					fin = y < int'(end_y);
				end
			endcase
			pen_x = COORD_WIDTH'(x);
			pen_y = COORD_WIDTH'(y);
			slope_err = ERR_WIDTH'(d);
			if (fin) drawing = 1'b0;
			p.final_pixel = fin;
			pixels_due.push_back(p);
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			cmd_valid <= 1'b0;
		end else begin
			if (cmd_valid && !cmd_stall) begin
				trace_cmd(cmd);
				items_sent++;
			end
			// A stalled command stays on the bus unchanged.
			if (!(cmd_valid && cmd_stall)) begin
				if (cmds_pending.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
					cmd <= cmds_pending.pop_front();
					cmd_valid <= 1'b1;
				end else begin
					cmd_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			pix_stall <= 1'b0;
		end else if (hold_left > 0) begin
			pix_stall <= 1'b1;
			hold_left--;
		end else if (hold_armed) begin
			hold_armed = 1'b0;
			hold_left = 400;
			pix_stall <= 1'b1;
		end else begin
			pix_stall <= ($urandom_range(99) < recv_gap_pct);
		end
	end

	always @(posedge clk) begin : watch
		pix_t want;
		if (arst_n && pix_valid && !pix_stall) begin
			if (pixels_due.size() == 0) begin
				$error("pixel transfer with none pending: x %0d y %0d",
					pix.pixel_x, pix.pixel_y);
				fail_count++;
			end else begin
				want = pixels_due.pop_front();
				if (pix.pixel_x !== want.pixel_x) begin
					$error("pixel_x: expected %0d, got %0d", want.pixel_x, pix.pixel_x);
					fail_count++;
				end
				if (pix.pixel_y !== want.pixel_y) begin
					$error("pixel_y: expected %0d, got %0d", want.pixel_y, pix.pixel_y);
					fail_count++;
				end
				if (pix.pixel_rgb !== want.pixel_rgb) begin
					$error("pixel_rgb: expected %h, got %h", want.pixel_rgb, pix.pixel_rgb);
					fail_count++;
				end
				if (pix.final_pixel !== want.final_pixel) begin
					$error("final_pixel: expected %b, got %b",
						want.final_pixel, pix.final_pixel);
					fail_count++;
				end
			end
		end
	end

	task automatic push_cmd(input logic mode, input int sx, input int sy,
			input int fx, input int fy);
		cmd_t c;
		c.mode = mode;
		c.start_x = COORD_WIDTH'(sx);
		c.start_y = COORD_WIDTH'(sy);
		c.finish_x = COORD_WIDTH'(fx);
		c.finish_y = COORD_WIDTH'(fy);
		cmds_pending.push_back(c);
		items_queued++;
	endtask

	// Step commands carry random endpoint bits, which the block must ignore.
	task automatic push_step();
		push_cmd(MODE_STEP, $urandom_range(4095), $urandom_range(4095),
			$urandom_range(4095), $urandom_range(4095));
	endtask

	// Called at a rising edge; the write lands on the first edge with ready high.
	task automatic write_color(input logic [COLOR_WIDTH-1:0] c);
		cfg_data <= c;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		color_reg = c;
		cfg_valid <= 1'b0;
	endtask

	task automatic settle();
		while (items_sent != items_queued || pixels_due.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	// One line with random endpoints, mostly walked to its end; some are cut
	// short by the next load and some get extra steps after the end.
	task automatic queue_line(input int span);
		int ax, ay, bx, by, ddx, ddy, n, steps, pick;
		ax = int'($urandom_range(4095)) - 2048;
		ay = int'($urandom_range(4095)) - 2048;
		if ($urandom_range(7) == 0) ax = $urandom_range(1) ? 2047 : -2048;
		if ($urandom_range(7) == 0) ay = $urandom_range(1) ? 2047 : -2048;
		ddx = int'($urandom_range(2 * span)) - span;
		ddy = int'($urandom_range(2 * span)) - span;
		if ($urandom_range(9) == 0) ddy = $urandom_range(1) ? ddx : -ddx;
		bx = ax + ddx;
		if (bx > 2047 || bx < -2048) bx = ax - ddx;
		by = ay + ddy;
		if (by > 2047 || by < -2048) by = ay - ddy;
		ddx = (bx > ax) ? bx - ax : ax - bx;
		ddy = (by > ay) ? by - ay : ay - by;
		n = ((ddx > ddy) ? ddx : ddy) + 1;
		push_cmd(MODE_LOAD, ax, ay, bx, by);
		pick = $urandom_range(99);
		if (pick < 80) steps = n;
		else if (pick < 90) steps = n + 1 + $urandom_range(2);
		else steps = $urandom_range(n - 1);
		items_made += 1 + ((steps < n) ? steps : n);
		repeat (steps) push_step();
	endtask

	task automatic random_lines(input int budget);
		int goal, pick;
		goal = items_made + budget;
		queue_line(250);
		while (items_made < goal) begin
			pick = $urandom_range(99);
			if (pick < 85) begin
				queue_line($urandom_range(8));
			end else if (pick < 97) begin
				queue_line($urandom_range(40, 9));
			end else if (pick < 99) begin
				push_cmd(MODE_LOAD, $urandom_range(4095), $urandom_range(4095),
					$urandom_range(4095), $urandom_range(4095));
				repeat ($urandom_range(5)) push_step();
				items_made++;
			end else begin
				push_step();
			end
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		write_color('0);

		send_gap_pct = 6;
		recv_gap_pct = 82;
		push_step();
		// Single point, then a step once the block is idle again.
		push_cmd(MODE_LOAD, -2048, 2047, -2048, 2047);
		repeat (2) push_step();
		// Shallow line ending on the right edge of the coordinate range.
		push_cmd(MODE_LOAD, 2045, 0, 2047, 1);
		repeat (3) push_step();
		// Steep falling line ending on the bottom edge.
		push_cmd(MODE_LOAD, 0, -2046, 1, -2048);
		repeat (3) push_step();
		// Swapped endpoints with equal rise and run.
		push_cmd(MODE_LOAD, 2, 2, 0, 0);
		repeat (3) push_step();
		// Corner to corner, abandoned by the flat line that follows.
		push_cmd(MODE_LOAD, 2047, -2048, -2048, 2047);
		repeat (2) push_step();
		push_cmd(MODE_LOAD, 3, 0, 0, 0);
		repeat (4) push_step();
		settle();

		write_color('1);
		random_lines(450);
		settle();

		send_gap_pct = 82;
		recv_gap_pct = 6;
		write_color(COLOR_WIDTH'($urandom_range(24'hFFFFFF)));
		random_lines(450);
		settle();

		send_gap_pct = 0;
		recv_gap_pct = 0;
		write_color(COLOR_WIDTH'($urandom_range(24'hFFFFFF)));
		hold_armed = 1'b1;
		random_lines(450);
		settle();

		repeat (10) @(posedge clk);
		if (fail_count == 0 && pixels_due.size() == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/lr_pkg.sv
hw/rtl/lr_setup.sv
hw/rtl/lr_walker.sv
hw/rtl/line_rasterizer_unit.sv
test/testbench.sv
